// ===== design/ksa_pkg.sv =====
package ksa_pkg;

  localparam int TABLE_SIZE = 16;
  localparam int IDX_W      = 4;
  localparam int KEY_W      = 5;
  localparam int CMD_W      = 3;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;
  localparam int USB_POS    = 18;
  localparam int SD_POS     = 17;

  localparam logic [31:0] OVR_MASK0 = 32'h0000_0003;
  localparam logic [31:0] OVR_MASK1 = 32'h0094_FFE0;

  // Bit i gives the key word group of table entry i.
  localparam logic [TABLE_SIZE-1:0] KEY_GRP = 16'b1111_1111_1111_1100;

  localparam logic [31:0] KEY_BITS [TABLE_SIZE] = '{
    32'h0000_0003, 32'h0000_0001, 32'h0000_0400, 32'h0000_0800,
    32'h0000_2000, 32'h0000_1000, 32'h0000_0100, 32'h0000_8000,
    32'h0004_0000, 32'h0000_4000, 32'h0000_0200, 32'h0080_0000,
    32'h0000_0080, 32'h0000_0040, 32'h0010_0000, 32'h0000_0020
  };

  localparam logic [CMD_W-1:0] CMD_SCAN        = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PRESS       = 3'd1;
  localparam logic [CMD_W-1:0] CMD_RELEASE     = 3'd2;
  localparam logic [CMD_W-1:0] CMD_RELEASE_ALL = 3'd3;
  localparam logic [CMD_W-1:0] CMD_RESET_REP   = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_REMOTE_MASK_EN = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ALT_KEY_INDEX  = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_REPEAT   = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NEXT_REPEAT    = 4'd3;

  localparam logic [IDX_W-1:0] ALT_KEY_RESET      = 4'd11;
  localparam logic [15:0]      FIRST_REPEAT_RESET = 16'd500;
  localparam logic [15:0]      NEXT_REPEAT_RESET  = 16'd175;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [IDX_W-1:0] key_index;
    logic [31:0]      raw_word_zero;
    logic [31:0]      raw_word_one;
    logic [31:0]      raw_word_two;
    logic             override_active;
    logic             usb_present;
    logic [31:0]      now_ms;
  } in_item_t;

  typedef struct packed {
    logic [31:0]      status_zero;
    logic [31:0]      status_one;
    logic [31:0]      status_two;
    logic [KEY_W-1:0] pressed_key;
    logic [KEY_W-1:0] clicked_key;
    logic [KEY_W-1:0] repeat_key;
    logic             remote_level;
    logic [15:0]      pulse_length;
  } out_item_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

  typedef struct packed {
    logic             remote_mask_enable;
    logic [IDX_W-1:0] alt_key_index;
    logic [15:0]      first_repeat_ms;
    logic [15:0]      next_repeat_ms;
  } cfg_t;

endpackage

// ===== design/ksa_chan_if.sv =====
interface ksa_chan_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== design/ksa_cfg_regs.sv =====
module ksa_cfg_regs (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_valid,
  input  ksa_pkg::cfg_wr_t wr,
  output logic            wr_ready,
  output ksa_pkg::cfg_t   cfg
);
  import ksa_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign wr_ready = 1'b1;
  assign cfg      = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_valid) begin
      case (wr.index)
        REG_REMOTE_MASK_EN: cfg_nxt.remote_mask_enable = wr.data[0];
        REG_ALT_KEY_INDEX:  cfg_nxt.alt_key_index = wr.data[IDX_W-1:0];
        REG_FIRST_REPEAT:   cfg_nxt.first_repeat_ms = wr.data[15:0];
        REG_NEXT_REPEAT:    cfg_nxt.next_repeat_ms = wr.data[15:0];
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.remote_mask_enable <= 1'b0;
      cfg_r.alt_key_index      <= ALT_KEY_RESET;
      cfg_r.first_repeat_ms    <= FIRST_REPEAT_RESET;
      cfg_r.next_repeat_ms     <= NEXT_REPEAT_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end
endmodule

// ===== design/ksa_core.sv =====
module ksa_core #(
  parameter int TABLE_LEN = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               acc,
  input  ksa_pkg::in_item_t  item,
  input  ksa_pkg::cfg_t      cfg,
  output ksa_pkg::out_item_t res
);
  import ksa_pkg::*;

  localparam logic [KEY_W-1:0] TL_K = KEY_W'(TABLE_LEN);

  logic [31:0]           new0_r, new1_r, new0_nxt, new1_nxt;
  logic [31:0]           ovr0_r, ovr1_r, ovr0_nxt, ovr1_nxt;
  logic [KEY_W-1:0]      held_r, held_nxt;
  logic [31:0]           time_r, time_nxt;
  logic                  once_r, once_nxt;
  logic [15:0]           cnt_r, cnt_nxt;
  logic [15:0]           last_r, last_nxt;

  logic [TABLE_SIZE-1:0] down_v;
  logic [TABLE_SIZE-1:0] click_v;
  logic [KEY_W-1:0]      pressed;
  logic [KEY_W-1:0]      clicked;
  logic [31:0]           s2;
  logic                  lvl;
  logic [IDX_W-1:0]      held_idx;
  logic [31:0]           elapsed;
  logic [15:0]           thr;
  logic                  fire;

  always_comb begin
    for (int i = 0; i < TABLE_SIZE; i++) begin
      down_v[i]  = (i < TABLE_LEN) &&
                   (((KEY_GRP[i] ? item.raw_word_one : item.raw_word_zero) & KEY_BITS[i])
                    == 32'h0);
      click_v[i] = down_v[i] && (((KEY_GRP[i] ? new1_r : new0_r) & KEY_BITS[i]) != 32'h0);
    end
    pressed = '0;
    clicked = '0;
    for (int i = TABLE_SIZE - 1; i >= 0; i--) begin
      if (down_v[i]) pressed = KEY_W'(i + 1);
      if (click_v[i]) clicked = KEY_W'(i + 1);
    end
  end

  assign held_idx = IDX_W'(held_r - KEY_W'(1));
  assign elapsed  = item.now_ms - time_r;
  assign thr      = once_r ? cfg.next_repeat_ms : cfg.first_repeat_ms;
  assign fire     = !elapsed[31] && (elapsed > {16'h0, thr});

  always_comb begin
    new0_nxt = new0_r;
    new1_nxt = new1_r;
    ovr0_nxt = ovr0_r;
    ovr1_nxt = ovr1_r;
    held_nxt = held_r;
    time_nxt = time_r;
    once_nxt = once_r;
    cnt_nxt  = cnt_r;
    last_nxt = last_r;
    res      = '0;
    s2       = item.raw_word_two;
    lvl      = 1'b0;
    case (item.command)
      CMD_PRESS: begin
        if ({1'b0, item.key_index} < TL_K) begin
          if (KEY_GRP[item.key_index]) ovr1_nxt = ovr1_r & ~KEY_BITS[item.key_index];
          else ovr0_nxt = ovr0_r & ~KEY_BITS[item.key_index];
        end
      end
      CMD_RELEASE: begin
        if ({1'b0, item.key_index} < TL_K) begin
          if (KEY_GRP[item.key_index]) ovr1_nxt = ovr1_r | KEY_BITS[item.key_index];
          else ovr0_nxt = ovr0_r | KEY_BITS[item.key_index];
        end
      end
      CMD_RELEASE_ALL: begin
        ovr0_nxt = ovr0_r | OVR_MASK0;
        ovr1_nxt = ovr1_r | OVR_MASK1;
      end
      CMD_RESET_REP: begin
        held_nxt = '0;
      end
      CMD_SCAN: begin
        new0_nxt = item.raw_word_zero;
        new1_nxt = item.raw_word_one;
        if (item.override_active) begin
          res.status_zero = (item.raw_word_zero & ~OVR_MASK0) | (ovr0_r & OVR_MASK0);
          res.status_one  = (item.raw_word_one & ~OVR_MASK1) | (ovr1_r & OVR_MASK1);
        end else begin
          res.status_zero = item.raw_word_zero;
          res.status_one  = item.raw_word_one;
          if ({1'b0, cfg.alt_key_index} < TL_K) s2 = s2 | KEY_BITS[cfg.alt_key_index];
        end
        s2[USB_POS] = s2[USB_POS] | item.usb_present;
        lvl         = s2[USB_POS];
        if (lvl) begin
          if (cnt_r != 16'hFFFF) cnt_nxt = cnt_r + 16'd1;
        end else if (cnt_r != 16'h0) begin
          last_nxt = cnt_r;
          cnt_nxt  = 16'h0;
        end
        s2[SD_POS] = 1'b0;
        if (cfg.remote_mask_enable) s2[USB_POS] = 1'b0;

        if (clicked != '0) begin
          held_nxt       = clicked;
          once_nxt       = 1'b0;
          time_nxt       = item.now_ms;
          res.repeat_key = clicked;
        end else if (held_r != '0 && down_v[held_idx]) begin
          if (fire) begin
            once_nxt       = 1'b1;
            time_nxt       = item.now_ms;
            res.repeat_key = held_r;
          end
        end else begin
          held_nxt = '0;
        end

        res.status_two   = s2;
        res.pressed_key  = pressed;
        res.clicked_key  = clicked;
        res.remote_level = lvl;
        res.pulse_length = last_nxt;
      end
      default: begin
        res = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      new0_r <= '0;
      new1_r <= '0;
      ovr0_r <= OVR_MASK0;
      ovr1_r <= OVR_MASK1;
      held_r <= '0;
      time_r <= '0;
      once_r <= 1'b0;
      cnt_r  <= '0;
      last_r <= '0;
    end else if (acc) begin
      new0_r <= new0_nxt;
      new1_r <= new1_nxt;
      ovr0_r <= ovr0_nxt;
      ovr1_r <= ovr1_nxt;
      held_r <= held_nxt;
      time_r <= time_nxt;
      once_r <= once_nxt;
      cnt_r  <= cnt_nxt;
      last_r <= last_nxt;
    end
  end
endmodule

// ===== design/ksa_skid.sv =====
module ksa_skid #(
  parameter type payload_t = logic
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  payload_t in_data,
  output logic     in_ready,
  output logic     out_valid,
  output payload_t out_data,
  input  logic     out_ready
);
  logic     out_valid_r;
  logic     skid_valid_r;
  payload_t out_data_r;
  payload_t skid_data_r;
  logic     acc;

  assign in_ready  = !skid_valid_r;
  assign acc       = in_valid && !skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_ready || !out_valid_r) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= acc;
      end
    end else if (acc) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready || !out_valid_r) begin
      if (skid_valid_r) out_data_r <= skid_data_r;
      else if (acc) out_data_r <= in_data;
    end else if (acc) begin
      skid_data_r <= in_data;
    end
  end
endmodule

// ===== design/keypad_scan_override_autorepeat.sv =====
// Output: each result is registered in the output register, or in the skid entry while the output stalls.
// Throughput: one transaction per cycle; the input side keeps accepting while a result
// waits, until the single skid entry behind the output register is also full.
// Reset: synchronous, active low; key words clear, the override mask reads all released,
// autorepeat and pulse counters clear and the registers take their documented defaults.
module keypad_scan_override_autorepeat #(
  parameter int NUM_KEYS = 16
) (
  input logic clk,
  input logic rst_n,
  ksa_chan_if.sink   in_chan,
  ksa_chan_if.source out_chan,
  ksa_chan_if.sink   cfg_chan
);
  import ksa_pkg::*;

  localparam int TABLE_LEN = (NUM_KEYS < TABLE_SIZE) ? NUM_KEYS : TABLE_SIZE;

  cfg_t      cfg;
  out_item_t res;
  logic      in_ready;
  logic      acc;

  assign in_chan.ready = in_ready;
  assign acc           = in_chan.valid && in_ready;

  ksa_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (cfg_chan.valid),
    .wr       (cfg_chan.data),
    .wr_ready (cfg_chan.ready),
    .cfg      (cfg)
  );

  ksa_core #(.TABLE_LEN(TABLE_LEN)) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .acc   (acc),
    .item  (in_chan.data),
    .cfg   (cfg),
    .res   (res)
  );

  ksa_skid #(.payload_t(out_item_t)) u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_data   (res),
    .in_ready  (in_ready),
    .out_valid (out_chan.valid),
    .out_data  (out_chan.data),
    .out_ready (out_chan.ready)
  );
endmodule

// ===== design/ksa_checker.sv =====
module ksa_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input ksa_pkg::out_item_t out_data
);
  import ksa_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("Stalled result changed or was dropped.");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !out_valid |=> out_valid)
    else $error("Accepted transaction did not reach the output in one cycle.");

  a_click_pressed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.clicked_key != '0 |->
      out_data.pressed_key != '0 && out_data.pressed_key <= out_data.clicked_key)
    else $error("Clicked key reported without an earlier or equal pressed key.");

  a_click_repeat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.clicked_key != '0 |-> out_data.repeat_key == out_data.clicked_key)
    else $error("A click did not start the autorepeat key.");
endmodule

bind keypad_scan_override_autorepeat ksa_checker u_ksa_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_chan.valid),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_data  (out_chan.data)
);
